[design/ppp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants for the programmable parallel port
// Operation codes, address selects, register state and result bundle.
// ----------------------------------------------------------------------------
package ppp_pkg;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_STROBE_A = 2'd2,
    OP_STROBE_B = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_PORT_A  = 2'd0,
    SEL_PORT_B  = 2'd1,
    SEL_PORT_C  = 2'd2,
    SEL_CONTROL = 2'd3
  } sel_t;

  localparam int unsigned CS_W = 6;
  localparam logic [2:0] BIT_INDEX_MASK = 3'h7;

  // Control word bit positions
  localparam int unsigned CW_MODE_SET = 7;
  localparam int unsigned CW_A_MODE_HI = 6;
  localparam int unsigned CW_A_MODE_LO = 5;
  localparam int unsigned CW_A_INPUT = 4;
  localparam int unsigned CW_B_MODE = 2;
  localparam int unsigned CW_B_INPUT = 1;

  // Port C bits that carry the interrupt enables
  localparam int unsigned PC_EN_A = 4;
  localparam int unsigned PC_EN_B = 2;

  typedef struct packed {
    logic [7:0] port_a;
    logic [7:0] port_b;
    logic [7:0] port_c;
    logic [7:0] control;
    logic       en_a;
    logic       en_b;
  } ppp_state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       irq_a;
    logic       irq_b;
  } ppp_flags_t;

endpackage

[design/ppp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_core: event decode and register update
// Computes the next register state and the bus/irq flags for one event.
// ----------------------------------------------------------------------------
module ppp_core (
  input  ppp_pkg::ppp_state_t              cur,
  input  logic [ppp_pkg::CS_W-1:0]         dev_sel,
  input  logic [1:0]                       operation,
  input  logic [7:0]                       address,
  input  logic [7:0]                       write_data,
  input  logic [7:0]                       port_a_in,
  input  logic [7:0]                       port_b_in,
  output ppp_pkg::ppp_state_t              nxt,
  output ppp_pkg::ppp_flags_t              flags
);

  logic       hit;
  logic [1:0] sel;
  logic       a_mode0;
  logic       b_mode0;
  logic [2:0] pos;

  assign hit     = (address[7:2] == dev_sel);
  assign sel     = address[1:0];
  assign a_mode0 = (cur.control[ppp_pkg::CW_A_MODE_HI:ppp_pkg::CW_A_MODE_LO] == 2'b00);
  assign b_mode0 = !cur.control[ppp_pkg::CW_B_MODE];
  assign pos     = write_data[3:1] & ppp_pkg::BIT_INDEX_MASK;

  always_comb begin
    nxt   = cur;
    flags = '0;
    unique case (ppp_pkg::op_t'(operation))
      ppp_pkg::OP_READ: begin
        if (hit) begin
          unique case (ppp_pkg::sel_t'(sel))
            ppp_pkg::SEL_PORT_A: begin
              if (a_mode0) begin
                flags.read_data  = cur.port_a;
                flags.read_valid = 1'b1;
              end
            end
            ppp_pkg::SEL_PORT_B: begin
              if (b_mode0) begin
                flags.read_data  = cur.port_b;
                flags.read_valid = 1'b1;
              end
            end
            ppp_pkg::SEL_PORT_C: begin
              if (b_mode0) begin
                flags.read_data = cur.port_c;
              end else begin
                // status byte: enables only
                flags.read_data[ppp_pkg::PC_EN_A] = cur.en_a;
                flags.read_data[ppp_pkg::PC_EN_B] = cur.en_b;
              end
              flags.read_valid = 1'b1;
            end
            ppp_pkg::SEL_CONTROL: begin
            end
            default: begin
            end
          endcase
        end
      end
      ppp_pkg::OP_WRITE: begin
        if (hit) begin
          unique case (ppp_pkg::sel_t'(sel))
            ppp_pkg::SEL_CONTROL: begin
              if (write_data[ppp_pkg::CW_MODE_SET]) begin
                nxt.control = write_data;
              end else begin
                nxt.port_c[pos] = write_data[0];
              end
            end
            ppp_pkg::SEL_PORT_A: begin
              if (a_mode0) nxt.port_a = write_data;
            end
            ppp_pkg::SEL_PORT_B: begin
              if (b_mode0) nxt.port_b = write_data;
            end
            ppp_pkg::SEL_PORT_C: begin
              nxt.port_c = write_data;
            end
            default: begin
            end
          endcase
          nxt.en_a = nxt.port_c[ppp_pkg::PC_EN_A];
          nxt.en_b = nxt.port_c[ppp_pkg::PC_EN_B];
        end
      end
      ppp_pkg::OP_STROBE_A: begin
        if (!a_mode0 && cur.control[ppp_pkg::CW_A_INPUT]) begin
          nxt.port_a  = port_a_in;
          flags.irq_a = cur.en_a;
        end
      end
      ppp_pkg::OP_STROBE_B: begin
        if (!b_mode0 && cur.control[ppp_pkg::CW_B_INPUT]) begin
          nxt.port_b  = port_b_in;
          flags.irq_b = cur.en_b;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[design/programmable_parallel_port.sv]
`timescale 1ns / 1ps
// A result appears on the out_ port in the cycle after its input transfer.
// Throughput: one event per cycle if unstalled; the register state updates in the
// same edge that captures the result register, so back-to-back events see prior
// effects. in_stall rises only while a held result is stalled on the output side.
// Reset (rst_n low, synchronous) clears ports A/B/C, control word, enables,
// device select and the output valid.
// ----------------------------------------------------------------------------
// programmable_parallel_port: three-port parallel peripheral
// Bus read/write decode, port C bit set/reset, strobe latching with irq flags.
// ----------------------------------------------------------------------------
module programmable_parallel_port (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [ppp_pkg::CS_W-1:0]  cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [7:0]                in_address,
  input  logic [7:0]                in_write_data,
  input  logic [7:0]                in_port_a_in,
  input  logic [7:0]                in_port_b_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_read_data,
  output logic                      out_read_valid,
  output logic                      out_irq_a,
  output logic                      out_irq_b,
  output logic [7:0]                out_port_a_out,
  output logic [7:0]                out_port_b_out,
  output logic [7:0]                out_port_c_out
);

  logic [ppp_pkg::CS_W-1:0] dev_sel_r;
  ppp_pkg::ppp_state_t      state_r;
  ppp_pkg::ppp_state_t      state_nxt;
  ppp_pkg::ppp_flags_t      flags_nxt;
  ppp_pkg::ppp_flags_t      flags_r;
  logic                     out_valid_r;
  logic                     in_xfer;
  logic                     out_xfer;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  ppp_core u_core (
    .cur         (state_r),
    .dev_sel     (dev_sel_r),
    .operation   (in_operation),
    .address     (in_address),
    .write_data  (in_write_data),
    .port_a_in   (in_port_a_in),
    .port_b_in   (in_port_b_in),
    .nxt         (state_nxt),
    .flags       (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_sel_r   <= '0;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) dev_sel_r <= cfg_wr_data;
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; port values come from state_r, which updates on the same edge
  always_ff @(posedge clk) begin
    if (in_xfer) flags_r <= flags_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = flags_r.read_data;
  assign out_read_valid = flags_r.read_valid;
  assign out_irq_a      = flags_r.irq_a;
  assign out_irq_b      = flags_r.irq_b;
  assign out_port_a_out = state_r.port_a;
  assign out_port_b_out = state_r.port_b;
  assign out_port_c_out = state_r.port_c;

`ifndef SYNTH
  // A bus read never also raises an interrupt
  a_read_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(flags_r.read_valid && (flags_r.irq_a || flags_r.irq_b)))
    else $error("read result carries an irq flag");

  // Input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

  // A strobe interrupt implies the peripheral byte was latched
  a_irq_a_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && flags_nxt.irq_a) |=> (state_r.port_a == $past(in_port_a_in)))
    else $error("irq_a raised without port A latch");

  a_irq_b_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && flags_nxt.irq_b) |=> (state_r.port_b == $past(in_port_b_in)))
    else $error("irq_b raised without port B latch");

  // No new transfer while stalled, so the held port values stay put
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(state_r))
    else $error("register state changed while output stalled");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for programmable_parallel_port
// Drives bus reads, bus writes and port strobes through the valid/stall input
// channel and checks every result against an in-bench model of the port state.
// Device select is reprogrammed between phases. Both sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SEL_W = ppp_pkg::CS_W;

  typedef struct {
    ppp_pkg::op_t op;
    logic [7:0]   addr;
    logic [7:0]   wdata;
    logic [7:0]   a_in;
    logic [7:0]   b_in;
  } port_event_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       irq_a;
    logic       irq_b;
    logic [7:0] port_a;
    logic [7:0] port_b;
    logic [7:0] port_c;
  } port_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [SEL_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_operation = '0;
  logic [7:0]       in_address = '0;
  logic [7:0]       in_write_data = '0;
  logic [7:0]       in_port_a_in = '0;
  logic [7:0]       in_port_b_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_read_data;
  logic             out_read_valid;
  logic             out_irq_a;
  logic             out_irq_b;
  logic [7:0]       out_port_a_out;
  logic [7:0]       out_port_b_out;
  logic [7:0]       out_port_c_out;

  port_event_t         pending_events[$];
  port_result_t        expected_results[$];
  ppp_pkg::ppp_state_t port_regs;
  logic [SEL_W-1:0]    cs_model;
  logic         in_fired = 1'b0;
  logic         calm = 1'b0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           errors = 0;
  int           quiet_cycles = 0;

  localparam int WATCHDOG_LIMIT = 1000;

  programmable_parallel_port uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_port_a_in  (in_port_a_in),
    .in_port_b_in  (in_port_b_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_read_valid(out_read_valid),
    .out_irq_a     (out_irq_a),
    .out_irq_b     (out_irq_b),
    .out_port_a_out(out_port_a_out),
    .out_port_b_out(out_port_b_out),
    .out_port_c_out(out_port_c_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Port model: applies one event to port_regs and returns the result it gives
  function automatic port_result_t apply_event(input port_event_t ev);
    port_result_t  r;
    logic          hit;
    ppp_pkg::sel_t sel;
    logic [1:0]    mode_a;
    logic [2:0]    pos;
    r = '0;
    hit = (ev.addr[7:2] == cs_model);
    sel = ppp_pkg::sel_t'(ev.addr[1:0]);
    mode_a = port_regs.control[ppp_pkg::CW_A_MODE_HI:ppp_pkg::CW_A_MODE_LO];
    if (ev.op == ppp_pkg::OP_READ && hit) begin
      case (sel)
        ppp_pkg::SEL_PORT_A: if (mode_a == 2'd0) begin
          r.read_data = port_regs.port_a;
          r.read_valid = 1'b1;
        end
        ppp_pkg::SEL_PORT_B: if (!port_regs.control[ppp_pkg::CW_B_MODE]) begin
          r.read_data = port_regs.port_b;
          r.read_valid = 1'b1;
        end
        ppp_pkg::SEL_PORT_C: begin
          r.read_valid = 1'b1;
          if (!port_regs.control[ppp_pkg::CW_B_MODE]) begin
            r.read_data = port_regs.port_c;
          end else begin
            // status byte: only the two enables
            r.read_data[ppp_pkg::PC_EN_A] = port_regs.en_a;
            r.read_data[ppp_pkg::PC_EN_B] = port_regs.en_b;
          end
        end
        default: ;
      endcase
    end else if (ev.op == ppp_pkg::OP_WRITE && hit) begin
      case (sel)
        ppp_pkg::SEL_CONTROL: begin
          if (!ev.wdata[ppp_pkg::CW_MODE_SET]) begin
            pos = ev.wdata[3:1] & ppp_pkg::BIT_INDEX_MASK;
            port_regs.port_c[pos] = ev.wdata[0];
          end else begin
            port_regs.control = ev.wdata;
          end
        end
        ppp_pkg::SEL_PORT_A: if (mode_a == 2'd0) port_regs.port_a = ev.wdata;
        ppp_pkg::SEL_PORT_B:
          if (!port_regs.control[ppp_pkg::CW_B_MODE]) port_regs.port_b = ev.wdata;
        default: port_regs.port_c = ev.wdata;
      endcase
      port_regs.en_a = port_regs.port_c[ppp_pkg::PC_EN_A];
      port_regs.en_b = port_regs.port_c[ppp_pkg::PC_EN_B];
    end else if (ev.op == ppp_pkg::OP_STROBE_A) begin
      if (mode_a != 2'd0 && port_regs.control[ppp_pkg::CW_A_INPUT]) begin
        port_regs.port_a = ev.a_in;
        r.irq_a = port_regs.en_a;
      end
    end else if (ev.op == ppp_pkg::OP_STROBE_B) begin
      if (port_regs.control[ppp_pkg::CW_B_MODE] && port_regs.control[ppp_pkg::CW_B_INPUT]) begin
        port_regs.port_b = ev.b_in;
        r.irq_b = port_regs.en_b;
      end
    end
    r.port_a = port_regs.port_a;
    r.port_b = port_regs.port_b;
    r.port_c = port_regs.port_c;
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
      errors++;
    end
  endtask

  // Monitor: model update on input transfers, checks on output transfers
  always @(posedge clk) begin
    port_result_t want;
    port_event_t  ev;
    if (!rst_n) begin
      port_regs = '0;
      cs_model = '0;
      in_fired = 1'b0;
    end else begin
      if (cfg_wr_en) cs_model = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("read_data", want.read_data, out_read_data);
          compare_field("read_valid", 8'(want.read_valid), 8'(out_read_valid));
          compare_field("irq_a", 8'(want.irq_a), 8'(out_irq_a));
          compare_field("irq_b", 8'(want.irq_b), 8'(out_irq_b));
          compare_field("port_a_out", want.port_a, out_port_a_out);
          compare_field("port_b_out", want.port_b, out_port_b_out);
          compare_field("port_c_out", want.port_c, out_port_c_out);
        end
      end
      in_fired = in_valid && !in_stall;
      if (in_fired) begin
        ev.op = ppp_pkg::op_t'(in_operation);
        ev.addr = in_address;
        ev.wdata = in_write_data;
        ev.a_in = in_port_a_in;
        ev.b_in = in_port_b_in;
        expected_results.push_back(apply_event(ev));
      end
    end
  end

  // Input driver
  always @(negedge clk) begin
    port_event_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fired) begin
      // payload held while stalled
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      in_gap = $urandom_range(0, 7);
    end else if (pending_events.size() > 0) begin
      ev = pending_events.pop_front();
      in_valid <= 1'b1;
      in_operation <= ev.op;
      in_address <= ev.addr;
      in_write_data <= ev.wdata;
      in_port_a_in <= ev.a_in;
      in_port_b_in <= ev.b_in;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output stall bursts
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      out_gap = $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_event(input ppp_pkg::op_t op, input logic [7:0] addr,
                             input logic [7:0] wdata, input logic [7:0] a_in,
                             input logic [7:0] b_in);
    port_event_t ev;
    ev.op = op;
    ev.addr = addr;
    ev.wdata = wdata;
    ev.a_in = a_in;
    ev.b_in = b_in;
    pending_events.push_back(ev);
  endtask

  task automatic queue_random(input int count, input logic [SEL_W-1:0] cs);
    int           kind;
    ppp_pkg::op_t op;
    logic [1:0]   sel;
    logic [7:0]   addr;
    logic [7:0]   wdata;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      wdata = 8'($urandom);
      sel = 2'($urandom);
      if (kind < 15) begin
        op = ppp_pkg::OP_WRITE;
        sel = ppp_pkg::SEL_CONTROL;
        wdata[ppp_pkg::CW_MODE_SET] = 1'b1;
      end else if (kind < 27) begin
        op = ppp_pkg::OP_WRITE;
        sel = ppp_pkg::SEL_CONTROL;
        wdata[ppp_pkg::CW_MODE_SET] = 1'b0;
      end else if (kind < 42) begin
        op = ppp_pkg::OP_WRITE;
        sel = 2'($urandom_range(0, 2));
      end else if (kind < 62) begin
        op = ppp_pkg::OP_READ;
      end else if (kind < 81) begin
        op = ppp_pkg::OP_STROBE_A;
      end else begin
        op = ppp_pkg::OP_STROBE_B;
      end
      addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : {cs, sel};
      queue_event(op, addr, wdata, 8'($urandom), 8'($urandom));
    end
  endtask

  // wait until the channel is empty and every result has been checked
  task automatic drain();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_dev_sel(input logic [SEL_W-1:0] cs);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cs;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [SEL_W-1:0] cs;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, device select still at its reset value
    queue_event(ppp_pkg::OP_READ, 8'h00, 8'h00, 8'hFF, 8'hFF);
    queue_event(ppp_pkg::OP_WRITE, 8'h00, 8'hFF, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_WRITE, 8'h01, 8'h5A, 8'hFF, 8'h00);
    queue_event(ppp_pkg::OP_WRITE, 8'h02, 8'hFF, 8'h00, 8'hFF);
    queue_event(ppp_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_READ, 8'h01, 8'h00, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_READ, 8'h02, 8'h00, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_READ, 8'h03, 8'h00, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_WRITE, 8'h03, 8'h08, 8'h00, 8'h00);  // clear PC4
    queue_event(ppp_pkg::OP_WRITE, 8'h03, 8'h09, 8'h00, 8'h00);  // set PC4
    queue_event(ppp_pkg::OP_WRITE, 8'h03, 8'h0E, 8'h00, 8'h00);  // clear PC7
    queue_event(ppp_pkg::OP_WRITE, 8'hFC, 8'h00, 8'h00, 8'h00);  // not selected
    queue_event(ppp_pkg::OP_READ, 8'hFE, 8'h00, 8'h00, 8'h00);
    // A mode 1 input, B mode 1 input
    queue_event(ppp_pkg::OP_WRITE, 8'h03, 8'hB6, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_STROBE_A, 8'h00, 8'h00, 8'hFF, 8'h00);
    queue_event(ppp_pkg::OP_STROBE_B, 8'h00, 8'h00, 8'hFF, 8'h00);
    queue_event(ppp_pkg::OP_STROBE_B, 8'h00, 8'h00, 8'h00, 8'hFF);
    queue_event(ppp_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_READ, 8'h01, 8'h00, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_READ, 8'h02, 8'h00, 8'h00, 8'h00);   // status byte
    queue_event(ppp_pkg::OP_WRITE, 8'h00, 8'h55, 8'h00, 8'h00);  // ignored outside mode 0
    queue_event(ppp_pkg::OP_WRITE, 8'h03, 8'hFF, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_STROBE_A, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_event(ppp_pkg::OP_WRITE, 8'h02, 8'h00, 8'h00, 8'h00);  // drop both enables
    queue_event(ppp_pkg::OP_STROBE_A, 8'h00, 8'h00, 8'hAA, 8'h00);
    queue_event(ppp_pkg::OP_WRITE, 8'h03, 8'h80, 8'h00, 8'h00);  // all mode 0
    queue_event(ppp_pkg::OP_STROBE_A, 8'h00, 8'h00, 8'h3C, 8'h00);
    queue_event(ppp_pkg::OP_STROBE_B, 8'h00, 8'h00, 8'h00, 8'hC3);

    set_dev_sel('1);
    queue_random(300, '1);
    cs = SEL_W'($urandom_range(1, 62));
    set_dev_sel(cs);
    queue_random(300, cs);
    set_dev_sel('0);
    queue_random(150, '0);
    cs = SEL_W'($urandom);
    set_dev_sel(cs);
    calm = 1'b1;
    queue_random(250, cs);
    drain();
    repeat (3) @(negedge clk);

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
